// ----- sv/fppi_pkg.sv -----
// ----------------------------------------------------------------------------
// fppi_pkg
// Shared types, request codes, register map and limits of the fixed-point
// PI controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fppi_pkg;

   localparam int FRAC_BITS  = 15;
   localparam int ADDR_WIDTH = 5;
   localparam int CSR_IDX_W  = ADDR_WIDTH - 2;

   // request codes
   localparam logic [1:0] REQ_PROCESS = 2'd0;
   localparam logic [1:0] REQ_PRELOAD = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_SHIFT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_GAIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_SHIFT  = 3'd5;

   localparam logic signed [17:0] ERR_MAX = 18'sd32767;
   localparam logic signed [17:0] ERR_MIN = -18'sd32768;

   localparam logic signed [47:0] ACC_MAX_W = 48'sh0000_7fff_ffff;
   localparam logic signed [47:0] ACC_MIN_W = -48'sh0000_8000_0000;

   typedef struct packed {
      logic signed [15:0] out_min;
      logic signed [15:0] out_max;
      logic [14:0]        prop_gain;
      logic [3:0]         prop_shift;
      logic [14:0]        int_gain;
      logic [3:0]         int_shift;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      out_min:    16'sh8000,
      out_max:    16'sh7fff,
      prop_gain:  15'd0,
      prop_shift: 4'd15,
      int_gain:   15'd0,
      int_shift:  4'd0
   };

   // error stage contents
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] err;
      logic signed [15:0] preload;
   } err_stage_type;

   // gain stage contents
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [30:0] prop_term;
      logic signed [30:0] int_step;
      logic signed [15:0] preload;
   } gain_stage_type;

endpackage

// ----- sv/fppi_req_if.sv -----
// ----------------------------------------------------------------------------
// fppi_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fppi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [16:0] setpoint;
   logic signed [16:0] feedback;
   logic signed [15:0] preload_value;

   modport source (
      output valid, req_type, setpoint, feedback, preload_value,
      input  ready
   );

   modport sink (
      input  valid, req_type, setpoint, feedback, preload_value,
      output ready
   );
endinterface

// ----- sv/fppi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fppi_rsp_if
// Response channel: valid/ready handshake with the controller output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fppi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] control;

   modport source (
      output valid, control,
      input  ready
   );

   modport sink (
      input  valid, control,
      output ready
   );
endinterface

// ----- sv/fppi_csr.sv -----
// ----------------------------------------------------------------------------
// fppi_csr
// APB-style register file holding the output limits, gains and shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fppi_csr import fppi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[ADDR_WIDTH-1:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_OUT_MIN:    cfg_in.out_min    = pwdata[15:0];
            CSR_OUT_MAX:    cfg_in.out_max    = pwdata[15:0];
            CSR_PROP_GAIN:  cfg_in.prop_gain  = pwdata[14:0];
            CSR_PROP_SHIFT: cfg_in.prop_shift = pwdata[3:0];
            CSR_INT_GAIN:   cfg_in.int_gain   = pwdata[14:0];
            CSR_INT_SHIFT:  cfg_in.int_shift  = pwdata[3:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_OUT_MIN:    prdata = 32'(cfg_ff.out_min);
         CSR_OUT_MAX:    prdata = 32'(cfg_ff.out_max);
         CSR_PROP_GAIN:  prdata = 32'(cfg_ff.prop_gain);
         CSR_PROP_SHIFT: prdata = 32'(cfg_ff.prop_shift);
         CSR_INT_GAIN:   prdata = 32'(cfg_ff.int_gain);
         CSR_INT_SHIFT:  prdata = 32'(cfg_ff.int_shift);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/fppi_gain.sv -----
// ----------------------------------------------------------------------------
// fppi_gain
// Front pipeline: saturated error register, then the proportional and
// integral-increment products, each shifted right arithmetically.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fppi_gain import fppi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   fppi_req_if.sink       req,
   output logic           out_valid,
   input  logic           out_ready,
   output gain_stage_type out_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   err_stage_type      s1_ff;
   err_stage_type      s1_in;
   logic               s2_valid_ff;
   logic               s2_valid_in;
   gain_stage_type     s2_ff;
   gain_stage_type     s2_in;
   logic               s1_ready;
   logic               s2_ready;
   logic signed [17:0] diff;
   logic signed [31:0] prop_prod;
   logic signed [31:0] int_prod;
   logic signed [31:0] prop_shr;
   logic signed [31:0] int_shr;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   // error, saturated to 16 bits
   always_comb begin
      diff = 18'(req.setpoint) - 18'(req.feedback);
      s1_in.req_type = req.req_type;
      s1_in.preload  = req.preload_value;
      if (diff > ERR_MAX) begin
         s1_in.err = ERR_MAX[15:0];
      end else if (diff < ERR_MIN) begin
         s1_in.err = ERR_MIN[15:0];
      end else begin
         s1_in.err = diff[15:0];
      end
      s1_valid_in = s1_ready ? req.valid : s1_valid_ff;
   end

   // |product| < 2^30, so 31 bits hold the shifted terms
   always_comb begin
      prop_prod = $signed({1'b0, cfg.prop_gain}) * s1_ff.err;
      int_prod  = $signed({1'b0, cfg.int_gain}) * s1_ff.err;
      prop_shr  = prop_prod >>> cfg.prop_shift;
      int_shr   = int_prod >>> cfg.int_shift;
      s2_in.req_type  = s1_ff.req_type;
      s2_in.preload   = s1_ff.preload;
      s2_in.prop_term = prop_shr[30:0];
      s2_in.int_step  = int_shr[30:0];
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_ff <= s2_in;
      end
   end

endmodule

// ----- sv/fppi_integ.sv -----
// ----------------------------------------------------------------------------
// fppi_integ
// Integral accumulator with the dynamic anti-windup clamp, output sum and
// clamp, preload and clear handling, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fppi_integ import fppi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  gain_stage_type in_data,
   fppi_rsp_if.source     rsp
);

   logic signed [31:0] acc_ff;
   logic signed [31:0] acc_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic signed [15:0] control_ff;
   logic signed [15:0] control_in;
   logic               fire;
   logic signed [32:0] lim_lo;
   logic signed [32:0] lim_hi;
   logic signed [47:0] lo_q;
   logic signed [47:0] hi_q;
   logic signed [32:0] acc_sum;
   logic signed [47:0] acc_lo;
   logic signed [47:0] acc_hi;
   logic signed [47:0] acc_sat;
   logic signed [31:0] acc_proc;
   logic signed [31:0] out_sum;
   logic signed [31:0] out_lo;
   logic signed [31:0] out_hi;
   logic signed [15:0] pre_lo;
   logic signed [15:0] pre_val;

   assign in_ready  = !out_valid_ff || rsp.ready;
   assign fire      = in_valid && in_ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.control = control_ff;

   always_comb begin
      // window for the integral: [min(out_min - P, 0), max(out_max - P, 0)]
      lim_lo = 33'(cfg.out_min) - 33'(in_data.prop_term);
      lim_hi = 33'(cfg.out_max) - 33'(in_data.prop_term);
      if (lim_lo > 33'sd0) begin
         lim_lo = '0;
      end
      if (lim_hi < 33'sd0) begin
         lim_hi = '0;
      end
      lo_q = 48'(lim_lo) <<< FRAC_BITS;
      hi_q = 48'(lim_hi) <<< FRAC_BITS;

      acc_sum = 33'(acc_ff) + 33'(in_data.int_step);
      acc_lo  = (48'(acc_sum) < lo_q) ? lo_q : 48'(acc_sum);
      acc_hi  = (acc_lo > hi_q) ? hi_q : acc_lo;
      if (acc_hi > ACC_MAX_W) begin
         acc_sat = ACC_MAX_W;
      end else if (acc_hi < ACC_MIN_W) begin
         acc_sat = ACC_MIN_W;
      end else begin
         acc_sat = acc_hi;
      end
      acc_proc = acc_sat[31:0];

      // lower limit first, upper second
      out_sum = 32'(in_data.prop_term) + (acc_proc >>> FRAC_BITS);
      out_lo  = (out_sum < 32'(cfg.out_min)) ? 32'(cfg.out_min) : out_sum;
      out_hi  = (out_lo > 32'(cfg.out_max)) ? 32'(cfg.out_max) : out_lo;

      pre_lo  = (in_data.preload < cfg.out_min) ? cfg.out_min : in_data.preload;
      pre_val = (pre_lo > cfg.out_max) ? cfg.out_max : pre_lo;

      case (in_data.req_type)
         REQ_PROCESS: begin
            acc_in     = acc_proc;
            control_in = out_hi[15:0];
         end
         REQ_PRELOAD: begin
            acc_in     = 32'(pre_val) <<< FRAC_BITS;
            control_in = pre_val;
         end
         REQ_CLEAR: begin
            acc_in     = '0;
            control_in = '0;
         end
         default: begin
            acc_in     = acc_ff;
            control_in = '0;
         end
      endcase

      out_valid_in = in_ready ? in_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         control_ff <= control_in;
      end
   end

endmodule

// ----- sv/fixed_point_pi_controller.sv -----
// ----------------------------------------------------------------------------
// fixed_point_pi_controller
// Fixed-point parallel PI controller with dynamic anti-windup clamp.
//
// Requests arrive on the req channel (valid/ready): process a sample
// (setpoint, feedback), preload the output (bumpless transfer) or clear
// the integral. Every request returns exactly one control value on the rsp
// channel, in request order. Limits, gains and shifts are written through
// the APB-style port; pready is always high.
// Pipeline: error register, product register, result register.
// Throughput: one request per cycle while the receiver takes results; the
// accumulator update and the output clamp share the last stage, so
// back-to-back samples see each other's integral with no wait between them.
// Reset clears the pipeline, the integral and loads the default registers.
// When the receiver stalls, the result holds; stages behind it keep filling
// bubbles, and req.ready falls only once all three stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_pi_controller import fppi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fppi_req_if.sink              req,
   fppi_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type        cfg;
   logic           gain_valid;
   logic           gain_ready;
   gain_stage_type gain_data;

   fppi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fppi_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .out_valid (gain_valid),
      .out_ready (gain_ready),
      .out_data  (gain_data)
   );

   fppi_integ u_integ (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (gain_valid),
      .in_ready (gain_ready),
      .in_data  (gain_data),
      .rsp      (rsp)
   );

endmodule

// ----- sv/fppi_checker.sv -----
// ----------------------------------------------------------------------------
// fppi_checker
// Port-level checks of the PI controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fppi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_control
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // backpressure reaches the request side only through a stalled result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_control)))
      else $error("stalled result changed");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result dropped without transaction");

endmodule

bind fixed_point_pi_controller fppi_checker u_fppi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_control (rsp.control)
);

// ----- tb/fixed_point_pi_controller_checker.sv -----
// ----------------------------------------------------------------------------
// fixed_point_pi_controller_checker
// Watches the request, response and register ports of the PI controller.
// It keeps its own copy of the limits, gains and integral, predicts the
// control value of every accepted request and compares each response
// transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_pi_controller_checker import fppi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fppi_req_if                   req,
   fppi_rsp_if                   rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending
);

   cfg_type            regs;
   longint             integral_q15;
   logic signed [15:0] control_expected[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(string what);
      $display("[%0t] control check: %s", $time, what);
      fail_count++;
   endtask

   // lower bound applied first, so inverted limits end at hi
   function automatic longint clamp_lh(longint v, longint lo, longint hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic logic signed [15:0] controller_step(logic [1:0] kind,
                                                          logic signed [16:0] sp,
                                                          logic signed [16:0] fb,
                                                          logic signed [15:0] pv);
      longint err, p, lim_lo, lim_hi, acc, outv;
      outv = 0;
      case (kind)
         REQ_PROCESS: begin
            err = clamp_lh(longint'(sp) - longint'(fb), -32768, 32767);
            p   = (longint'(regs.prop_gain) * err) >>> regs.prop_shift;
            lim_lo = longint'(regs.out_min) - p;
            lim_hi = longint'(regs.out_max) - p;
            if (lim_lo > 0) lim_lo = 0;
            if (lim_hi < 0) lim_hi = 0;
            acc = integral_q15 + ((longint'(regs.int_gain) * err) >>> regs.int_shift);
            acc = clamp_lh(acc, lim_lo <<< FRAC_BITS, lim_hi <<< FRAC_BITS);
            acc = clamp_lh(acc, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
            integral_q15 = acc;
            outv = clamp_lh(p + (acc >>> FRAC_BITS), regs.out_min, regs.out_max);
         end
         REQ_PRELOAD: begin
            outv = clamp_lh(pv, regs.out_min, regs.out_max);
            integral_q15 = outv <<< FRAC_BITS;
         end
         REQ_CLEAR: integral_q15 = 0;
         default: ;
      endcase
      return outv[15:0];
   endfunction

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         regs         = CFG_RESET;
         integral_q15 = 0;
         control_expected.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_WIDTH-1:2])
               CSR_OUT_MIN:    regs.out_min    = pwdata[15:0];
               CSR_OUT_MAX:    regs.out_max    = pwdata[15:0];
               CSR_PROP_GAIN:  regs.prop_gain  = pwdata[14:0];
               CSR_PROP_SHIFT: regs.prop_shift = pwdata[3:0];
               CSR_INT_GAIN:   regs.int_gain   = pwdata[14:0];
               CSR_INT_SHIFT:  regs.int_shift  = pwdata[3:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (control_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, control %0d", rsp.control));
            end else begin
               want = control_expected.pop_front();
               if (rsp.control !== want)
                  report_mismatch($sformatf("got %0d, expected %0d", rsp.control, want));
            end
         end
         if (req.valid && req.ready)
            control_expected.push_back(controller_step(req.req_type, req.setpoint,
                                                       req.feedback, req.preload_value));
      end
      pending <= control_expected.size();
   end

endmodule

// ----- tb/fixed_point_pi_controller_tb.sv -----
// ----------------------------------------------------------------------------
// fixed_point_pi_controller_tb
// Stimulus and verdict for the PI controller. A directed pass covers the
// error saturation, preload, clear, the unused request code and inverted
// limits; random phases then reprogram every register and run process
// sequences with small errors, mixed with preloads, clears and wild samples;
// most run under random stalls on both channels. Checking lives in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_pi_controller_tb;
   import fppi_pkg::*;

   localparam logic [1:0] REQ_UNUSED     = 2'd3;
   localparam int         NUM_PHASES     = 9;
   localparam int         ITEMS_PER_PHASE = 150;
   localparam int         WATCHDOG_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int                    chk_fail;
   int                    chk_pending;
   int                    idle_cycles;
   bit                    idle_on;

   fppi_req_if req_bus ();
   fppi_rsp_if rsp_bus ();

   fixed_point_pi_controller u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fixed_point_pi_controller_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (chk_fail),
      .pending    (chk_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // response side back-pressure
   initial begin
      int run;
      run = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (run > 0) begin
            run--;
         end else if (!idle_on || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
            run = $urandom_range(0, 6);
         end else begin
            rsp_bus.ready <= 1'b0;
            run = pick_gap() - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_req(logic [1:0] kind, logic signed [16:0] sp,
                           logic signed [16:0] fb, logic signed [15:0] pv);
      int gap;
      gap = (idle_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.setpoint      <= sp;
      req_bus.feedback      <= fb;
      req_bus.preload_value <= pv;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic stop_req();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // wait until every response is back, then idle for pipeline slack
   task automatic wait_idle();
      do @(posedge clock); while (chk_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_program(logic signed [15:0] lo, logic signed [15:0] hi,
                              logic [14:0] pgain, logic [3:0] pshift,
                              logic [14:0] igain, logic [3:0] ishift);
      csr_write(CSR_OUT_MIN, {16'h0, lo});
      csr_write(CSR_OUT_MAX, {16'h0, hi});
      csr_write(CSR_PROP_GAIN, {17'h0, pgain});
      csr_write(CSR_PROP_SHIFT, {28'h0, pshift});
      csr_write(CSR_INT_GAIN, {17'h0, igain});
      csr_write(CSR_INT_SHIFT, {28'h0, ishift});
   endtask

   function automatic logic [14:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return 15'd0;
         1: return 15'h7fff;
         default: return 15'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_shift();
      case ($urandom_range(0, 3))
         0: return 4'd0;
         1: return 4'd15;
         default: return 4'($urandom);
      endcase
   endfunction

   task automatic program_random();
      logic signed [15:0] lo, hi, t;
      lo = 16'($urandom);
      hi = 16'($urandom);
      case ($urandom_range(0, 5))
         0: begin
            lo = 16'sh8000;
            hi = 16'sh7fff;
         end
         1: ; // leave as drawn, may be inverted
         default: if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
      endcase
      csr_program(lo, hi, pick_gain(), pick_shift(), pick_gain(), pick_shift());
   endtask

   task automatic send_random_item();
      logic [1:0]         kind;
      logic signed [16:0] sp, fb;
      logic signed [15:0] pv;
      int                 r, d;
      r    = $urandom_range(0, 99);
      kind = (r < 82) ? REQ_PROCESS : (r < 90) ? REQ_PRELOAD :
             (r < 96) ? REQ_CLEAR : REQ_UNUSED;
      sp = 17'($urandom);
      pv = 16'($urandom);
      case ($urandom_range(0, 4))
         0, 1, 2: begin
            d  = int'($urandom_range(0, 1024)) - 512;
            fb = sp - 17'(d);
         end
         3: begin
            d  = int'($urandom_range(0, 80000)) - 40000;
            fb = sp - 17'(d);
         end
         default: fb = 17'($urandom);
      endcase
      push_req(kind, sp, fb, pv);
   endtask

   initial begin
      reset                 = 1'b1;
      idle_on               = 1'b0;
      idle_cycles           = 0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = REQ_PROCESS;
      req_bus.setpoint      = '0;
      req_bus.feedback      = '0;
      req_bus.preload_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: no gain, the integral only moves by preload and clear
      push_req(REQ_PROCESS, 17'sd0, 17'sd0, 16'sd0);
      push_req(REQ_PRELOAD, 17'sd0, 17'sd0, 16'sh7fff);
      push_req(REQ_PROCESS, 17'sd5, -17'sd5, 16'sd0);
      push_req(REQ_UNUSED, 17'h1ffff, 17'h1ffff, 16'hffff);
      push_req(REQ_CLEAR, 17'sd0, 17'sd0, 16'sd0);
      stop_req();
      wait_idle();

      // full gains and limits, error saturates both ways
      csr_program(16'sh8000, 16'sh7fff, 15'h7fff, 4'd0, 15'h7fff, 4'd0);
      push_req(REQ_PROCESS, 17'h0ffff, 17'h10000, 16'sd0);
      push_req(REQ_PROCESS, 17'h0ffff, 17'h10000, 16'sd0);
      push_req(REQ_PROCESS, 17'h10000, 17'h0ffff, 16'sd0);
      push_req(REQ_PROCESS, 17'sd0, 17'sd0, 16'sd0);
      push_req(REQ_PRELOAD, 17'sd0, 17'sd0, 16'sh8000);
      push_req(REQ_PRELOAD, 17'sd0, 17'sd0, 16'sh7fff);
      push_req(REQ_UNUSED, 17'sd0, 17'sd0, 16'sd0);
      push_req(REQ_CLEAR, 17'sd0, 17'sd0, 16'sd0);
      stop_req();
      wait_idle();

      // narrow limits: wind up against the clamp, then unwind
      csr_program(-16'sd1000, 16'sd1000, 15'd16384, 4'd15, 15'h7fff, 4'd15);
      repeat (4) push_req(REQ_PROCESS, 17'sd500, 17'sd0, 16'sd0);
      repeat (3) push_req(REQ_PROCESS, -17'sd800, 17'sd0, 16'sd0);
      push_req(REQ_PRELOAD, 17'sd0, 17'sd0, 16'sd5000);
      push_req(REQ_PRELOAD, 17'sd0, 17'sd0, -16'sd5000);
      stop_req();
      wait_idle();

      // inverted limits: every output and preload clamp lands on the upper one
      csr_program(16'sd100, -16'sd100, 15'd300, 4'd2, 15'd300, 4'd4);
      push_req(REQ_PROCESS, 17'sd40, 17'sd0, 16'sd0);
      push_req(REQ_PRELOAD, 17'sd0, 17'sd0, 16'sd0);
      push_req(REQ_PROCESS, -17'sd40, 17'sd0, 16'sd0);
      stop_req();
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         program_random();
         idle_on = (ph % 3 != 0);
         repeat (ITEMS_PER_PHASE) send_random_item();
         stop_req();
         wait_idle();
         idle_on = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (chk_fail == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
